// ===== src/lzwd_pkg.sv =====
// Shared types and constants of the LZW decode string table.
// Used by the channel interfaces and by lzw_decode_dictionary; no dependencies.
package lzwd_pkg;

   // field widths of the channel words
   localparam int MODE_W   = 2;
   localparam int CODE_W   = 12;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 13;
   localparam int WORD_W   = 64;
   localparam int COUNT_W  = 7;
   localparam int CSR_W    = 4;

   // table entry widths
   localparam int LEN_W  = 13;
   localparam int MARK_W = 2;
   localparam int ROOT_W = 9;

   // result packing
   localparam int CHUNK_BYTES = 64;
   localparam int LANE_W      = 6;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_UNUSED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_CLEAR    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_END      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd4;

   // marker codes and the bytes that marker entries hold
   localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_CLEAR = 2'd1;
   localparam logic [MARK_W-1:0] MARK_END   = 2'd2;
   localparam logic [BYTE_W-1:0] CLEAR_BYTE = 8'hFE;
   localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFF;

   // root code size limits and reset value
   localparam logic [CSR_W-1:0] MIN_CODE_RESET = 4'd8;
   localparam logic [CSR_W-1:0] MIN_CODE_LO    = 4'd2;
   localparam logic [CSR_W-1:0] MIN_CODE_HI    = 4'd8;

   // resolved table entry
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [CODE_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic [MARK_W-1:0] marker;
   } ent_type;

   // stored entry of an added string (never a marker)
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [CODE_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
   } slot_type;

endpackage

// ===== src/lzwd_if.sv =====
// Channel interfaces of the LZW decode string table: request, response, csr.
// Depends on lzwd_pkg for the field widths.
interface lzwd_req_if;
   logic                            valid;
   logic                            ready;
   logic [lzwd_pkg::MODE_W-1:0]     mode;
   logic [lzwd_pkg::CODE_W-1:0]     code;
   logic [lzwd_pkg::BYTE_W-1:0]     new_byte;
   logic [lzwd_pkg::CODE_W-1:0]     prev_code;

   modport source (output valid, mode, code, new_byte, prev_code, input ready);
   modport sink   (input valid, mode, code, new_byte, prev_code, output ready);
endinterface

interface lzwd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lzwd_pkg::STATUS_W-1:0]   status;
   logic [lzwd_pkg::VALUE_W-1:0]    value;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_0;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_1;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_2;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_3;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_4;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_5;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_6;
   logic [lzwd_pkg::WORD_W-1:0]     bytes_7;
   logic [lzwd_pkg::COUNT_W-1:0]    byte_count;
   logic                            last;

   modport source (output valid, status, value, bytes_0, bytes_1, bytes_2, bytes_3,
                   bytes_4, bytes_5, bytes_6, bytes_7, byte_count, last,
                   input ready);
   modport sink   (input valid, status, value, bytes_0, bytes_1, bytes_2, bytes_3,
                   bytes_4, bytes_5, bytes_6, bytes_7, byte_count, last,
                   output ready);
endinterface

interface lzwd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lzwd_pkg::CSR_W-1:0]      min_code_size;

   modport source (output valid, min_code_size, input ready);
   modport sink   (input valid, min_code_size, output ready);
endinterface

// ===== src/lzw_decode_dictionary.sv =====
// Clear goes to ST_DONE; add writes its entry in ST_LOOK unless the table is full; first
// byte and decode walk the prefix chain; decodes over 64 bytes go via the string buffer.
// Requests are taken only in ST_IDLE; the walk reads the entry memory once per cycle
// and the string buffer drains one byte per cycle, pausing until each word is taken. Root
// and marker entries are decoded from the root size, added entries live below next_free.
// Reset (synchronous, active high) leaves the table as a clear with min_code_size 8.
module lzw_decode_dictionary #(
   parameter int TABLE_SIZE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   lzwd_req_if.sink         req,
   lzwd_rsp_if.source       rsp,
   lzwd_csr_if.sink         csr
);

   localparam int IW      = $clog2(TABLE_SIZE);
   localparam int LW      = $clog2(TABLE_SIZE + 1);
   localparam int VALUE_W = lzwd_pkg::VALUE_W;
   localparam int LEN_W   = lzwd_pkg::LEN_W;
   localparam int COUNT_W = lzwd_pkg::COUNT_W;
   localparam int ROOT_W  = lzwd_pkg::ROOT_W;
   localparam int CODE_W  = lzwd_pkg::CODE_W;
   localparam int LANE_W  = lzwd_pkg::LANE_W;
   localparam int BUS_W   = lzwd_pkg::CHUNK_BYTES * lzwd_pkg::BYTE_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_CHUNK = 3'd4;
   localparam logic [2:0] ST_FILL  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // address classes of a table read
   localparam logic [2:0] CLS_NONE = 3'd0;
   localparam logic [2:0] CLS_ROOT = 3'd1;
   localparam logic [2:0] CLS_CLR  = 3'd2;
   localparam logic [2:0] CLS_END  = 3'd3;
   localparam logic [2:0] CLS_MEM  = 3'd4;

   // control state
   logic [2:0]                        state_ff, state_in;
   logic [lzwd_pkg::CSR_W-1:0]        msize_ff, msize_in;
   logic [ROOT_W-1:0]                 roots_ff, roots_in;
   logic [LW-1:0]                     next_free_ff, next_free_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // item and walk registers
   logic [lzwd_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [CODE_W-1:0]                 code_ff, code_in;
   logic [lzwd_pkg::BYTE_W-1:0]       nbyte_ff, nbyte_in;
   logic [CODE_W-1:0]                 prev_ff, prev_in;
   logic [LW-1:0]                     len_ff, len_in;
   logic [LW-1:0]                     pos_ff, pos_in;
   logic [IW-1:0]                     rd_ff, rd_in;
   logic [IW-1:0]                     rdq_ff, rdq_in;
   logic [lzwd_pkg::STATUS_W-1:0]     pend_status_ff, pend_status_in;
   logic [VALUE_W-1:0]                pend_value_ff, pend_value_in;

   // result word registers
   logic [lzwd_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [VALUE_W-1:0]                value_ff, value_in;
   logic [BUS_W-1:0]                  bytes_ff, bytes_in;
   logic [COUNT_W-1:0]                count_ff, count_in;
   logic                              last_ff, last_in;

   // memories and their read registers
   lzwd_pkg::slot_type                entry_mem [TABLE_SIZE];
   lzwd_pkg::slot_type                mem_rd_ff;
   logic [lzwd_pkg::BYTE_W-1:0]       string_mem [TABLE_SIZE];
   logic [lzwd_pkg::BYTE_W-1:0]       buf_rd_ff;
   logic [2:0]                        cls_ff;
   logic [lzwd_pkg::BYTE_W-1:0]       aq_ff;

   // combinational helpers
   logic [CODE_W-1:0]                 rd_addr;
   logic [2:0]                        cls_now;
   lzwd_pkg::ent_type                 ent;
   logic                              mem_we;
   lzwd_pkg::slot_type                mem_wdata;
   logic                              buf_we;
   logic [LW-1:0]                     pos_m1;
   logic [LW:0]                       nl_sum;
   logic [LW-1:0]                     nl;
   logic [lzwd_pkg::CSR_W-1:0]        msize_clamp;
   logic [ROOT_W-1:0]                 roots_new;
   logic                              small_path;
   logic                              fin_all;
   logic                              req_fire;

   assign req_fire   = req.valid && req.ready;
   assign pos_m1     = pos_ff - LW'(1);
   assign small_path = (len_ff <= LW'(lzwd_pkg::CHUNK_BYTES));
   assign fin_all    = ((LW'(rdq_ff) + LW'(1)) == len_ff);

   // clamp the root size and derive the root count for a clear
   always_comb begin
      msize_clamp = msize_ff;
      if (msize_ff < lzwd_pkg::MIN_CODE_LO) begin
         msize_clamp = lzwd_pkg::MIN_CODE_LO;
      end else if (msize_ff > lzwd_pkg::MIN_CODE_HI) begin
         msize_clamp = lzwd_pkg::MIN_CODE_HI;
      end
      roots_new = ROOT_W'(1) << msize_clamp;
   end

   // classify the table address being read this cycle
   always_comb begin
      if ({1'b0, rd_addr} < 13'(roots_ff)) begin
         cls_now = CLS_ROOT;
      end else if ({1'b0, rd_addr} == 13'(roots_ff)) begin
         cls_now = CLS_CLR;
      end else if ({1'b0, rd_addr} == 13'(roots_ff) + 13'd1) begin
         cls_now = CLS_END;
      end else if ({1'b0, rd_addr} < 13'(next_free_ff)) begin
         cls_now = CLS_MEM;
      end else begin
         cls_now = CLS_NONE;
      end
   end

   // resolve the entry returned by last cycle's read
   always_comb begin
      ent = '0;
      case (cls_ff)
         CLS_ROOT: begin
            ent.data   = aq_ff;
            ent.length = LEN_W'(1);
         end
         CLS_CLR: begin
            ent.data   = lzwd_pkg::CLEAR_BYTE;
            ent.length = LEN_W'(1);
            ent.marker = lzwd_pkg::MARK_CLEAR;
         end
         CLS_END: begin
            ent.data   = lzwd_pkg::END_BYTE;
            ent.length = LEN_W'(1);
            ent.marker = lzwd_pkg::MARK_END;
         end
         CLS_MEM: begin
            ent.data   = mem_rd_ff.data;
            ent.prefix = mem_rd_ff.prefix;
            ent.length = mem_rd_ff.length;
         end
         default: begin
            ent = '0;
         end
      endcase
   end

   // length of an added string, saturated at the table size
   always_comb begin
      nl_sum = {1'b0, LW'(ent.length)} + (LW + 1)'(1);
      if (nl_sum > (LW + 1)'(TABLE_SIZE)) begin
         nl = LW'(TABLE_SIZE);
      end else begin
         nl = nl_sum[LW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      msize_in       = msize_ff;
      roots_in       = roots_ff;
      next_free_in   = next_free_ff;
      rsp_valid_in   = rsp_valid_ff;
      mode_in        = mode_ff;
      code_in        = code_ff;
      nbyte_in       = nbyte_ff;
      prev_in        = prev_ff;
      len_in         = len_ff;
      pos_in         = pos_ff;
      rd_in          = rd_ff;
      rdq_in         = rdq_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      status_in      = status_ff;
      value_in       = value_ff;
      bytes_in       = bytes_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      rd_addr        = code_ff;
      mem_we         = 1'b0;
      mem_wdata      = '0;
      buf_we         = 1'b0;

      // drop the result word once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // take a root size write
      if (csr.valid) begin
         msize_in = csr.min_code_size;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = (req.mode == lzwd_pkg::MODE_ADD) ? req.prev_code : req.code;
            if (req_fire) begin
               mode_in  = req.mode;
               code_in  = req.code;
               nbyte_in = req.new_byte;
               prev_in  = req.prev_code;
               if (req.mode == lzwd_pkg::MODE_CLEAR) begin
                  roots_in       = roots_new;
                  next_free_in   = LW'(roots_new) + LW'(2);
                  pend_status_in = lzwd_pkg::STAT_OK;
                  pend_value_in  = VALUE_W'(roots_new) + VALUE_W'(2);
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            case (mode_ff)
               lzwd_pkg::MODE_ADD: begin
                  if (next_free_ff == LW'(TABLE_SIZE)) begin
                     pend_status_in = lzwd_pkg::STAT_OVERFLOW;
                  end else begin
                     mem_we           = 1'b1;
                     mem_wdata.data   = nbyte_ff;
                     mem_wdata.prefix = prev_ff;
                     mem_wdata.length = LEN_W'(nl);
                     next_free_in     = next_free_ff + LW'(1);
                     pend_status_in   = lzwd_pkg::STAT_OK;
                  end
                  pend_value_in = VALUE_W'(next_free_ff);
                  state_in      = ST_DONE;
               end
               lzwd_pkg::MODE_DECODE, lzwd_pkg::MODE_FIRST: begin
                  pend_value_in = '0;
                  if (cls_ff == CLS_NONE) begin
                     pend_status_in = lzwd_pkg::STAT_UNUSED;
                     state_in       = ST_DONE;
                  end else if (mode_ff == lzwd_pkg::MODE_DECODE && cls_ff == CLS_CLR) begin
                     pend_status_in = lzwd_pkg::STAT_CLEAR;
                     state_in       = ST_DONE;
                  end else if (mode_ff == lzwd_pkg::MODE_DECODE && cls_ff == CLS_END) begin
                     pend_status_in = lzwd_pkg::STAT_END;
                     state_in       = ST_DONE;
                  end else begin
                     len_in   = LW'(ent.length);
                     pos_in   = LW'(ent.length);
                     state_in = ST_PREP;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PREP: begin
            // short strings build straight into the result word: wait for it to drain
            rd_addr = code_ff;
            if (!(mode_ff == lzwd_pkg::MODE_DECODE && small_path) || !rsp_valid_ff) begin
               if (mode_ff == lzwd_pkg::MODE_DECODE && small_path) begin
                  bytes_in = '0;
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // place one byte per cycle, last byte first, and follow the prefix
            rd_addr = ent.prefix;
            pos_in  = pos_m1;
            if (mode_ff == lzwd_pkg::MODE_DECODE) begin
               if (small_path) begin
                  bytes_in[{pos_m1[LANE_W-1:0], 3'b000} +: lzwd_pkg::BYTE_W] = ent.data;
               end else begin
                  buf_we = 1'b1;
               end
            end
            if (pos_ff == LW'(1)) begin
               if (mode_ff == lzwd_pkg::MODE_FIRST) begin
                  pend_status_in = lzwd_pkg::STAT_OK;
                  pend_value_in  = VALUE_W'(ent.data);
                  state_in       = ST_DONE;
               end else if (small_path) begin
                  rsp_valid_in = 1'b1;
                  status_in    = lzwd_pkg::STAT_OK;
                  value_in     = VALUE_W'(len_ff);
                  count_in     = COUNT_W'(len_ff);
                  last_in      = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rd_in    = '0;
                  state_in = ST_CHUNK;
               end
            end
         end
         ST_CHUNK: begin
            // start a result word once the last one has been taken
            if (!rsp_valid_ff) begin
               bytes_in = '0;
               rdq_in   = rd_ff;
               rd_in    = rd_ff + IW'(1);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            bytes_in[{rdq_ff[LANE_W-1:0], 3'b000} +: lzwd_pkg::BYTE_W] = buf_rd_ff;
            if (fin_all || (rdq_ff[LANE_W-1:0] == '1)) begin
               rsp_valid_in = 1'b1;
               status_in    = lzwd_pkg::STAT_OK;
               value_in     = VALUE_W'(len_ff);
               count_in     = COUNT_W'(rdq_ff[LANE_W-1:0]) + COUNT_W'(1);
               last_in      = fin_all;
               state_in     = fin_all ? ST_IDLE : ST_CHUNK;
            end else begin
               rdq_in = rd_ff;
               rd_in  = rd_ff + IW'(1);
            end
         end
         ST_DONE: begin
            // emit the single word of an item that carries no string
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               status_in    = pend_status_ff;
               value_in     = pend_value_ff;
               bytes_in     = '0;
               count_in     = '0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         msize_ff     <= lzwd_pkg::MIN_CODE_RESET;
         roots_ff     <= ROOT_W'(256);
         next_free_ff <= LW'(258);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msize_ff     <= msize_in;
         roots_ff     <= roots_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      code_ff        <= code_in;
      nbyte_ff       <= nbyte_in;
      prev_ff        <= prev_in;
      len_ff         <= len_in;
      pos_ff         <= pos_in;
      rd_ff          <= rd_in;
      rdq_ff         <= rdq_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      status_ff      <= status_in;
      value_ff       <= value_in;
      bytes_ff       <= bytes_in;
      count_ff       <= count_in;
      last_ff        <= last_in;
      cls_ff         <= cls_now;
      aq_ff          <= rd_addr[lzwd_pkg::BYTE_W-1:0];
   end

   // entry memory of added strings
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[next_free_ff[IW-1:0]] <= mem_wdata;
      end
      mem_rd_ff <= entry_mem[rd_addr[IW-1:0]];
   end

   // string buffer for results longer than one word
   always_ff @(posedge clock) begin
      if (buf_we) begin
         string_mem[pos_m1[IW-1:0]] <= ent.data;
      end
      buf_rd_ff <= string_mem[rd_ff];
   end

   // ports
   assign req.ready      = (state_ff == ST_IDLE);
   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.value      = value_ff;
   assign rsp.bytes_0    = bytes_ff[63:0];
   assign rsp.bytes_1    = bytes_ff[127:64];
   assign rsp.bytes_2    = bytes_ff[191:128];
   assign rsp.bytes_3    = bytes_ff[255:192];
   assign rsp.bytes_4    = bytes_ff[319:256];
   assign rsp.bytes_5    = bytes_ff[383:320];
   assign rsp.bytes_6    = bytes_ff[447:384];
   assign rsp.bytes_7    = bytes_ff[511:448];
   assign rsp.byte_count = count_ff;
   assign rsp.last       = last_ff;

`ifndef ASSERT_OFF
   a_next_free_range: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= LW'(TABLE_SIZE))
      else $error("next free slot beyond table");

   a_full_word_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> count_ff == COUNT_W'(lzwd_pkg::CHUNK_BYTES))
      else $error("partial result word before the final one");

   a_walk_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> pos_ff != '0)
      else $error("chain walk with no bytes left");
`endif

endmodule

// ===== tb/sv/lzw_decode_dictionary_tb.sv =====
// Self-checking testbench for the LZW decode string table (lzw_decode_dictionary).
// Depends on lzwd_pkg and the channel interfaces in lzwd_if; predicts every response word
// from its own copy of the table and compares it field by field.
module lzw_decode_dictionary_tb;
   import lzwd_pkg::*;

   localparam int TBL_DEPTH = 4096;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] new_byte;
      logic [CODE_W-1:0] prev_code;
   } req_word_t;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [WORD_W-1:0]   lane [8];
      logic [COUNT_W-1:0]  byte_count;
      logic                last;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset;

   lzwd_req_if req_ch ();
   lzwd_rsp_if rsp_ch ();
   lzwd_csr_if csr_ch ();

   lzw_decode_dictionary #(.TABLE_SIZE(TBL_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // predicted string table
   logic [BYTE_W-1:0]  tbl_byte   [TBL_DEPTH];
   logic [CODE_W-1:0]  tbl_prefix [TBL_DEPTH];
   logic [LEN_W-1:0]   tbl_len    [TBL_DEPTH];
   logic [MARK_W-1:0]  tbl_mark   [TBL_DEPTH];
   logic [VALUE_W-1:0] tbl_top;
   logic [CSR_W-1:0]   root_bits;
   logic [BYTE_W-1:0]  walk_bytes [TBL_DEPTH];

   req_word_t req_backlog [$];
   rsp_word_t rsp_expected [$];

   int  fail_count = 0;
   int  words_in = 0;
   int  pushed = 0;
   int  hold_at = 32'h7FFF_FFFF;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;
   int  req_gap = 0;
   int  req_calm = 0;
   int  rsp_gap = 0;
   int  rsp_calm = 0;

   // running estimate of the table, used only to aim the stimulus
   logic [CSR_W-1:0] plan_bits = MIN_CODE_RESET;
   int plan_top = 258;
   int seq_code = 0;

   function automatic int code_len(int c);
      return (c < TBL_DEPTH) ? int'(tbl_len[c]) : 0;
   endfunction

   function automatic int root_count(logic [CSR_W-1:0] bits);
      int m = bits;
      if (m < MIN_CODE_LO) m = MIN_CODE_LO;
      if (m > MIN_CODE_HI) m = MIN_CODE_HI;
      return 1 << m;
   endfunction

   function automatic void table_clear();
      int roots = root_count(root_bits);
      for (int i = 0; i < TBL_DEPTH; i++) begin
         tbl_byte[i]   = '0;
         tbl_prefix[i] = '0;
         tbl_len[i]    = '0;
         tbl_mark[i]   = MARK_NONE;
      end
      for (int i = 0; i < roots; i++) begin
         tbl_byte[i] = i[BYTE_W-1:0];
         tbl_len[i]  = 1;
      end
      tbl_byte[roots]     = CLEAR_BYTE;
      tbl_len[roots]      = 1;
      tbl_mark[roots]     = MARK_CLEAR;
      tbl_byte[roots + 1] = END_BYTE;
      tbl_len[roots + 1]  = 1;
      tbl_mark[roots + 1] = MARK_END;
      tbl_top = roots + 2;
   endfunction

   // queue one response word; string bytes come from walk_bytes[start +: cnt]
   function automatic void post_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] val,
                                       int start, int cnt, bit last);
      rsp_word_t r;
      int idx;
      r.status     = st;
      r.value      = val;
      r.byte_count = cnt[COUNT_W-1:0];
      r.last       = last;
      for (int w = 0; w < 8; w++) begin
         r.lane[w] = '0;
         for (int b = 0; b < 8; b++) begin
            idx = w * 8 + b;
            if (idx < cnt) r.lane[w][8*b +: 8] = walk_bytes[start + idx];
         end
      end
      rsp_expected.push_back(r);
   endfunction

   // advance the table by one accepted request word and queue its responses
   function automatic void table_apply(req_word_t w);
      int len, c, pos, nres, cnt, nl;
      case (w.mode)
         MODE_CLEAR: begin
            table_clear();
            post_result(STAT_OK, tbl_top, 0, 0, 1);
         end
         MODE_DECODE: begin
            len = code_len(w.code);
            if (len == 0) begin
               post_result(STAT_UNUSED, 0, 0, 0, 1);
            end else if (len == 1 && tbl_mark[w.code] != MARK_NONE) begin
               post_result((tbl_mark[w.code] == MARK_CLEAR) ? STAT_CLEAR : STAT_END,
                           0, 0, 0, 1);
            end else begin
               pos = len;
               c = w.code;
               while (pos > 0) begin
                  if (c < TBL_DEPTH) begin
                     walk_bytes[pos - 1] = tbl_byte[c];
                     c = tbl_prefix[c];
                  end else begin
                     walk_bytes[pos - 1] = '0;
                     c = 0;
                  end
                  pos--;
               end
               nres = (len + CHUNK_BYTES - 1) / CHUNK_BYTES;
               for (int k = 0; k < nres; k++) begin
                  cnt = len - k * CHUNK_BYTES;
                  if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
                  post_result(STAT_OK, len, k * CHUNK_BYTES, cnt, k == nres - 1);
               end
            end
         end
         MODE_ADD: begin
            if (tbl_top < TBL_DEPTH) begin
               nl = code_len(w.prev_code) + 1;
               if (nl > TBL_DEPTH) nl = TBL_DEPTH;
               tbl_byte[tbl_top]   = w.new_byte;
               tbl_prefix[tbl_top] = w.prev_code;
               tbl_len[tbl_top]    = nl;
               tbl_mark[tbl_top]   = MARK_NONE;
               post_result(STAT_OK, tbl_top, 0, 0, 1);
               tbl_top = tbl_top + 1;
            end else begin
               post_result(STAT_OVERFLOW, tbl_top, 0, 0, 1);
            end
         end
         default: begin
            len = code_len(w.code);
            c = w.code;
            if (len == 0) begin
               post_result(STAT_UNUSED, 0, 0, 0, 1);
            end else begin
               for (int s = len; s > 1; s--) c = (c < TBL_DEPTH) ? int'(tbl_prefix[c]) : 0;
               post_result(STAT_OK, (c < TBL_DEPTH) ? tbl_byte[c] : 8'h00, 0, 0, 1);
            end
         end
      endcase
   endfunction

   function automatic void report(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      fail_count++;
      if (fail_count <= 100)
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
   endfunction

   function automatic void check_word(rsp_word_t want, rsp_word_t got);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.value !== want.value) report("value", want.value, got.value);
      for (int i = 0; i < 8; i++)
         if (got.lane[i] !== want.lane[i])
            report($sformatf("bytes_%0d", i), want.lane[i], got.lane[i]);
      if (got.byte_count !== want.byte_count)
         report("byte_count", want.byte_count, got.byte_count);
      if (got.last !== want.last) report("last", want.last, got.last);
   endfunction

   // idle length: mostly none or short, a few long, with runs of no idling
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_code();
      int r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, TBL_DEPTH - 1);
      if (r < 55 && plan_top > 8) return $urandom_range(plan_top - 8, plan_top - 1);
      return $urandom_range(0, plan_top - 1);
   endfunction

   task automatic push_word(logic [MODE_W-1:0] mode, int code, int nb, int prev);
      req_word_t w;
      w.mode      = mode;
      w.code      = code[CODE_W-1:0];
      w.new_byte  = nb[BYTE_W-1:0];
      w.prev_code = prev[CODE_W-1:0];
      req_backlog.push_back(w);
      pushed++;
      if (mode == MODE_CLEAR) plan_top = root_count(plan_bits) + 2;
      else if (mode == MODE_ADD && plan_top < TBL_DEPTH) plan_top++;
   endtask

   // mostly decoder-like traffic: decode a code, then add a string built on it
   task automatic push_random();
      int r = $urandom_range(0, 99);
      int c;
      if (r < 4) begin
         push_word(MODE_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 255),
                   $urandom_range(0, 4095));
      end else if (r < 40) begin
         c = pick_code();
         seq_code = c;
         push_word(MODE_DECODE, c, $urandom_range(0, 255), $urandom_range(0, 4095));
      end else if (r < 75) begin
         c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : seq_code;
         push_word(MODE_ADD, $urandom_range(0, 4095), $urandom_range(0, 255), c);
      end else if (r < 95) begin
         push_word(MODE_FIRST, pick_code(), $urandom_range(0, 255), $urandom_range(0, 4095));
      end else begin
         push_word($urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 255),
                   $urandom_range(0, 4095));
      end
   endtask

   task automatic wait_idle(int settle);
      while (!(req_backlog.size() == 0 && !req_ch.valid && rsp_expected.size() == 0))
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_root_bits(logic [CSR_W-1:0] v);
      wait_idle(10);
      @(negedge clock);
      csr_ch.min_code_size <= v;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      plan_bits = v;
   endtask

   // clock: 10 time units
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      rsp_word_t got;
      req_word_t w;
      req_taken = 0;
      rsp_taken = 0;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) root_bits = csr_ch.min_code_size;
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1;
            words_in++;
            w.mode      = req_ch.mode;
            w.code      = req_ch.code;
            w.new_byte  = req_ch.new_byte;
            w.prev_code = req_ch.prev_code;
            table_apply(w);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken = 1;
            got.status     = rsp_ch.status;
            got.value      = rsp_ch.value;
            got.lane[0]    = rsp_ch.bytes_0;
            got.lane[1]    = rsp_ch.bytes_1;
            got.lane[2]    = rsp_ch.bytes_2;
            got.lane[3]    = rsp_ch.bytes_3;
            got.lane[4]    = rsp_ch.bytes_4;
            got.lane[5]    = rsp_ch.bytes_5;
            got.lane[6]    = rsp_ch.bytes_6;
            got.lane[7]    = rsp_ch.bytes_7;
            got.byte_count = rsp_ch.byte_count;
            got.last       = rsp_ch.last;
            if (rsp_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 100)
                  $error("response word with nothing expected: status %0d value %0d",
                         got.status, got.value);
            end else begin
               check_word(rsp_expected.pop_front(), got);
            end
         end
      end
   end

   // drive request words from the backlog, holding each until accepted
   always @(negedge clock) begin : drive_req
      req_word_t w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the offered word
      end else if (req_gap > 0) begin
         req_gap--;
         req_ch.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
         w = req_backlog.pop_front();
         req_ch.mode      <= w.mode;
         req_ch.code      <= w.code;
         req_ch.new_byte  <= w.new_byte;
         req_ch.prev_code <= w.prev_code;
         req_ch.valid     <= 1'b1;
         req_gap = pick_gap(req_calm);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // response ready: random stalls, plus one long hold-off once traffic is flowing
   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && words_in >= hold_at) begin
         hold_done = 1;
         hold_left = 400;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) rsp_gap = pick_gap(rsp_calm);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      logic [CSR_W-1:0] phase_bits [7] = '{4'd15, 4'd0, 4'd5, 4'd8, 4'd1, 4'd9, 4'd3};
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_CLEAR;
      req_ch.code = '0;
      req_ch.new_byte = '0;
      req_ch.prev_code = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.min_code_size = '0;
      root_bits = MIN_CODE_RESET;
      table_clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table as left by reset: roots, markers, unused codes
      push_word(MODE_DECODE, 0, 0, 0);
      push_word(MODE_DECODE, 255, 0, 0);
      push_word(MODE_DECODE, 256, 0, 0);
      push_word(MODE_DECODE, 257, 0, 0);
      push_word(MODE_DECODE, 258, 0, 0);
      push_word(MODE_DECODE, 4095, 255, 4095);
      push_word(MODE_FIRST, 258, 0, 0);
      push_word(MODE_FIRST, 4095, 0, 0);
      // adds: normal, chained, through markers, unused prefixes
      push_word(MODE_ADD, 0, 8'hAA, 65);
      push_word(MODE_ADD, 0, 8'h00, 258);
      push_word(MODE_ADD, 0, 8'h55, 256);
      push_word(MODE_ADD, 0, 8'hFF, 257);
      push_word(MODE_ADD, 0, 8'h12, 4095);
      push_word(MODE_ADD, 0, 8'h34, 3000);
      for (int c = 258; c <= 263; c++) push_word(MODE_DECODE, c, 0, 0);
      push_word(MODE_FIRST, 259, 0, 0);
      push_word(MODE_FIRST, 260, 0, 0);
      push_word(MODE_FIRST, 0, 0, 0);
      push_word(MODE_CLEAR, 0, 0, 0);
      push_word(MODE_DECODE, 258, 0, 0);

      // smallest roots: one chain that fills the whole table, then overflow
      write_root_bits(MIN_CODE_LO);
      push_word(MODE_CLEAR, 0, 0, 0);
      push_word(MODE_ADD, 0, $urandom_range(0, 255), root_count(MIN_CODE_LO));
      while (plan_top < TBL_DEPTH) begin
         push_word(MODE_ADD, $urandom_range(0, 4095), $urandom_range(0, 255), plan_top - 1);
         if (plan_top % 1024 == 0) begin
            push_word(MODE_DECODE, plan_top - 1, 0, 0);
            push_word(MODE_FIRST, plan_top - 1, 0, 0);
         end
      end
      push_word(MODE_ADD, 0, $urandom_range(0, 255), 7);
      push_word(MODE_ADD, 4095, 255, 4095);
      push_word(MODE_DECODE, 4095, 0, 0);
      push_word(MODE_FIRST, 4095, 0, 0);
      push_word(MODE_DECODE, root_count(MIN_CODE_LO) + 1, 0, 0);
      push_word(MODE_DECODE, root_count(MIN_CODE_LO), 0, 0);
      push_word(MODE_DECODE, 3, 0, 0);
      push_word(MODE_DECODE, 1000, 0, 0);

      // random phases over several root sizes, in and out of range
      foreach (phase_bits[p]) begin
         write_root_bits(phase_bits[p]);
         if (p == 0) hold_at = pushed + 8;
         push_word(MODE_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 255),
                   $urandom_range(0, 4095));
         repeat (39) push_random();
      end

      wait_idle(20);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== lzw_decode_dictionary.f =====
src/lzwd_pkg.sv
src/lzwd_if.sv
src/lzw_decode_dictionary.sv
tb/sv/lzw_decode_dictionary_tb.sv
